### hdl/ebmlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebmlt_pkg
// Shared widths, item codes, status codes and the level cell control type.
// ----------------------------------------------------------------------------
package ebmlt_pkg;

  localparam int REM_W = 56;
  localparam int ID_W = 32;
  localparam int OFF_W = 64;
  localparam int MAX_NEST_DEF = 8;

  // Item function codes.
  localparam logic [1:0] FUNC_HEADER = 2'd0;
  localparam logic [1:0] FUNC_CONSUME = 2'd1;
  localparam logic [1:0] FUNC_CLOSE = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_VINT = 3'd1;
  localparam logic [2:0] ST_TOO_DEEP = 3'd2;
  localparam logic [2:0] ST_NO_PARENT = 3'd3;
  localparam logic [2:0] ST_INF_IN_FIN = 3'd4;
  localparam logic [2:0] ST_EXCEEDS = 3'd5;
  localparam logic [2:0] ST_READ_PAST = 3'd6;

  // Control handed to every level cell.
  typedef struct packed {
    logic take;
    logic push_wr;
    logic wr_inf;
  } cell_ctrl_t;

endpackage

### hdl/ebmlt_level_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebmlt_level_cell
// One nesting level: remaining byte count and infinite flag. Subtracts the
// consumed count and passes the truncation mark on to the next level.
// ----------------------------------------------------------------------------
module ebmlt_level_cell #(
  parameter bit IS_ROOT = 1'b0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ebmlt_pkg::cell_ctrl_t    ctrl,
  input  logic [ebmlt_pkg::REM_W-1:0] n,
  input  logic [ebmlt_pkg::REM_W-1:0] wr_rem,
  input  logic                     active,
  input  logic                     cut_in,
  output logic                     cut_out,
  output logic                     cut_here,
  output logic                     inf,
  output logic [ebmlt_pkg::REM_W-1:0] rem
);

  logic                        upd;
  logic [ebmlt_pkg::REM_W-1:0] rem_sub;

  // A finite open level below the first cut takes the bytes.
  assign upd = ctrl.take && active && !cut_in && !inf;
  assign rem_sub = rem - n;
  assign cut_here = upd && (rem_sub == '0);
  assign cut_out = cut_in || cut_here;

  // Level storage.
  always_ff @(posedge clk) begin
    if (rst) begin
      inf <= IS_ROOT;
      rem <= '0;
    end else if (ctrl.push_wr) begin
      inf <= ctrl.wr_inf;
      rem <= wr_rem;
    end else if (upd) begin
      rem <= rem_sub;
    end
  end

endmodule

### hdl/ebml_element_nesting_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebml_element_nesting_tracker
// Parses element headers byte by byte and tracks a bounded stack of open
// elements held in a row of level cells.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | func, data_byte, count
// out     | output    | out_valid / out_ready| header_done ... byte_offset
//
// Each item goes through an accept, a take and a finish state. In the take
// state every level cell subtracts the count and the cut mark ripples down
// the cell row; the finish state does the varint step, the push and the
// result register, and a stalled output holds it until the previous result is taken.
// Synchronous reset leaves the infinite root as the only open level.
// ----------------------------------------------------------------------------
module ebml_element_nesting_tracker #(
  parameter int MAX_NEST = ebmlt_pkg::MAX_NEST_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  data_byte,
  input  logic [55:0] count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        header_done,
  output logic [31:0] elem_id,
  output logic [55:0] elem_size,
  output logic        is_infinite,
  output logic [3:0]  stack_depth,
  output logic [2:0]  status,
  output logic [55:0] skip_count,
  output logic [55:0] top_remaining,
  output logic [63:0] byte_offset
);

  localparam int DW = $clog2(MAX_NEST + 1);
  localparam int RW = ebmlt_pkg::REM_W;

  typedef enum logic [1:0] {S_IDLE, S_TAKE, S_FIN} state_t;
  state_t state;

  logic [1:0]  func_q;
  logic [7:0]  byte_q;
  logic [RW-1:0] count_q;
  logic        took;
  logic [2:0]  st_q;
  logic [RW-1:0] skip_q;

  logic [DW-1:0] depth;
  logic [DW-1:0] depth_m1;
  logic          phase;
  logic [3:0]    vleft;
  logic [3:0]    vwidth;
  logic [RW-1:0] vaccum;
  logic [ebmlt_pkg::ID_W-1:0] pending;
  logic [ebmlt_pkg::OFF_W-1:0] offset;

  ebmlt_pkg::cell_ctrl_t ctrl [MAX_NEST];
  logic [RW-1:0] n;
  logic [RW-1:0] wr_rem;
  logic          take;
  logic          push_wr;
  logic          wr_inf;
  logic [MAX_NEST:0] cut_chain;
  logic [MAX_NEST-1:0] cut_here;
  logic [MAX_NEST-1:0] cinf;
  logic [RW-1:0] crem [MAX_NEST];

  // Top level selection.
  logic          top_valid;
  logic          top_inf;
  logic [RW-1:0] top_rem;
  logic          top_fin;
  logic          par_inf;
  logic [RW-1:0] par_rem;

  assign depth_m1 = depth - 1'b1;
  assign top_valid = (depth != '0) && (depth <= DW'(MAX_NEST));

  always_comb begin
    top_inf = 1'b0;
    top_rem = '0;
    for (int i = 0; i < MAX_NEST; i++) begin
      if (DW'(i) == depth_m1) begin
        top_inf = cinf[i];
        top_rem = crem[i];
      end
    end
    par_inf = top_inf;
    par_rem = top_rem;
  end

  assign top_fin = top_valid && !top_inf;

  // Take decision for the item under work.
  logic allow;
  logic take_req;
  always_comb begin
    case (func_q)
      ebmlt_pkg::FUNC_HEADER:  n = RW'(1);
      ebmlt_pkg::FUNC_CONSUME: n = count_q;
      ebmlt_pkg::FUNC_CLOSE:   n = top_rem;
      default:                 n = '0;
    endcase
    allow = !top_fin || (top_rem >= n);
    case (func_q)
      ebmlt_pkg::FUNC_HEADER, ebmlt_pkg::FUNC_CONSUME: take_req = allow;
      ebmlt_pkg::FUNC_CLOSE:   take_req = top_fin;
      default:                 take_req = 1'b0;
    endcase
  end

  assign take = (state == S_TAKE) && take_req;

  // New depth after the take: the first level that reached zero.
  logic [DW-1:0] depth_cut;
  always_comb begin
    depth_cut = depth;
    for (int i = MAX_NEST - 1; i >= 0; i--) begin
      if (cut_here[i]) depth_cut = DW'(i);
    end
  end

  // Varint step on the header byte.
  logic [3:0]    lz_w;
  logic [3:0]    left_n;
  logic [3:0]    width_n;
  logic [RW-1:0] accum_n;
  logic          bad;
  logic [6:0]    sh;
  logic [RW-1:0] ones;
  logic          size_inf;
  logic [2:0]    push_st;
  logic          fin_go;
  logic          complete;

  always_comb begin
    lz_w = '0;
    for (int k = 0; k < 8; k++) begin
      if (lz_w == '0 && byte_q[7-k]) lz_w = 4'(k + 1);
    end
    bad = 1'b0;
    if (vleft == '0) begin
      bad = (byte_q == '0);
      width_n = lz_w;
      accum_n = RW'(byte_q & (8'hFF >> lz_w));
      left_n = lz_w - 4'd1;
    end else begin
      width_n = vwidth;
      accum_n = {vaccum[RW-9:0], byte_q};
      left_n = vleft - 4'd1;
    end
    complete = !bad && (left_n == '0);
    sh = 7'(RW) - 7'd7 * 7'(width_n);
    ones = {RW{1'b1}} >> sh;
    size_inf = (accum_n == ones);
    // Push checks against the parent, which is the current top.
    if (depth >= DW'(MAX_NEST)) push_st = ebmlt_pkg::ST_TOO_DEEP;
    else if (depth == '0) push_st = ebmlt_pkg::ST_NO_PARENT;
    else if (!par_inf && size_inf) push_st = ebmlt_pkg::ST_INF_IN_FIN;
    else if (!par_inf && (par_rem < accum_n)) push_st = ebmlt_pkg::ST_EXCEEDS;
    else push_st = ebmlt_pkg::ST_OK;
  end

  assign fin_go = (state == S_FIN) && (!out_valid || out_ready);
  assign push_wr = fin_go && took && complete && phase && (push_st == ebmlt_pkg::ST_OK);
  assign wr_inf = size_inf;
  assign wr_rem = accum_n;

  // Row of level cells.
  assign cut_chain[0] = 1'b0;
  for (genvar g = 0; g < MAX_NEST; g++) begin : g_cell
    assign ctrl[g].take = take;
    assign ctrl[g].push_wr = push_wr && (depth == DW'(g));
    assign ctrl[g].wr_inf = wr_inf;
    ebmlt_level_cell #(.IS_ROOT(g == 0)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl[g]),
      .n        (n),
      .wr_rem   (wr_rem),
      .active   (DW'(g) < depth),
      .cut_in   (cut_chain[g]),
      .cut_out  (cut_chain[g+1]),
      .cut_here (cut_here[g]),
      .inf      (cinf[g]),
      .rem      (crem[g])
    );
  end

  assign in_ready = (state == S_IDLE);

  // Sequencer, parser state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      depth <= DW'(1);
      phase <= 1'b0;
      vleft <= '0;
      vwidth <= '0;
      vaccum <= '0;
      pending <= '0;
      offset <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_q <= func;
            byte_q <= data_byte;
            count_q <= count;
            state <= S_TAKE;
          end
        end
        S_TAKE: begin
          took <= take && (func_q == ebmlt_pkg::FUNC_HEADER);
          st_q <= ebmlt_pkg::ST_OK;
          skip_q <= (func_q == ebmlt_pkg::FUNC_CLOSE && top_fin) ? top_rem : '0;
          if (take) begin
            depth <= depth_cut;
            offset <= offset + ebmlt_pkg::OFF_W'(n);
          end
          if ((func_q == ebmlt_pkg::FUNC_HEADER || func_q == ebmlt_pkg::FUNC_CONSUME)
              && !allow) begin
            st_q <= ebmlt_pkg::ST_READ_PAST;
            phase <= 1'b0;
            vleft <= '0;
            vwidth <= '0;
            vaccum <= '0;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            header_done <= 1'b0;
            elem_id <= '0;
            elem_size <= '0;
            is_infinite <= 1'b0;
            status <= st_q;
            skip_count <= skip_q;
            byte_offset <= offset;
            stack_depth <= 4'(depth);
            top_remaining <= top_fin ? top_rem : '0;
            if (took) begin
              if (bad) begin
                status <= ebmlt_pkg::ST_BAD_VINT;
                phase <= 1'b0;
                vleft <= '0;
                vwidth <= '0;
                vaccum <= '0;
              end else if (!complete) begin
                vleft <= left_n;
                vwidth <= width_n;
                vaccum <= accum_n;
              end else if (!phase) begin
                pending <= accum_n[ebmlt_pkg::ID_W-1:0];
                phase <= 1'b1;
                vleft <= '0;
                vwidth <= '0;
                vaccum <= '0;
              end else begin
                phase <= 1'b0;
                vleft <= '0;
                vwidth <= '0;
                vaccum <= '0;
                status <= push_st;
                if (push_st == ebmlt_pkg::ST_OK) begin
                  depth <= depth + 1'b1;
                  header_done <= 1'b1;
                  elem_id <= pending;
                  elem_size <= accum_n;
                  is_infinite <= size_inf;
                  stack_depth <= 4'(depth + 1'b1);
                  top_remaining <= size_inf ? '0 : accum_n;
                end
              end
            end
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The root level is never closed and the stack stays within its bound.
  a_depth_nonzero: assert property (@(posedge clk) disable iff (rst) depth != '0)
    else $error("stack lost its root level");
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(MAX_NEST))
    else $error("stack depth beyond its bound");
  a_root_inf: assert property (@(posedge clk) disable iff (rst) cinf[0])
    else $error("root level lost its infinite flag");
  a_done_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && header_done |-> status == ebmlt_pkg::ST_OK)
    else $error("pushed header reported with an error status");

endmodule

### tb/ebml_element_nesting_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebml_element_nesting_tracker_tb
// Self-checking bench for the element header parser and its nesting stack.
// A directed table opens the run; random well-formed headers, payload reads,
// closes and noise follow. Every result is compared, field by field, with
// the output of a stack predictor kept in the bench.
// ----------------------------------------------------------------------------
module ebml_element_nesting_tracker_tb;

  localparam int NEST = ebmlt_pkg::MAX_NEST_DEF;
  localparam int RANDOM_ITEMS = 1700;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [55:0] MASK56 = {56{1'b1}};

  typedef struct {
    bit        hd;
    bit [31:0] id;
    bit [55:0] sz;
    bit        inf;
    bit [3:0]  dep;
    bit [2:0]  st;
    bit [55:0] skip;
    bit [55:0] top;
    bit [63:0] off;
  } hdr_result_t;

  typedef struct {
    bit [1:0]  f;
    bit [7:0]  d;
    bit [55:0] c;
    bit        known;
    bit [2:0]  st;
    bit [3:0]  dep;
  } stim_row_t;

  typedef struct {
    bit [1:0]  f;
    bit [7:0]  d;
    bit [55:0] c;
  } stream_item_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  func;
  logic [7:0]  data_byte;
  logic [55:0] count;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        header_done;
  logic [31:0] elem_id;
  logic [55:0] elem_size;
  logic        is_infinite;
  logic [3:0]  stack_depth;
  logic [2:0]  status;
  logic [55:0] skip_count;
  logic [55:0] top_remaining;
  logic [63:0] byte_offset;

  ebml_element_nesting_tracker u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .data_byte(data_byte), .count(count),
    .out_valid(out_valid), .out_ready(out_ready),
    .header_done(header_done), .elem_id(elem_id), .elem_size(elem_size),
    .is_infinite(is_infinite), .stack_depth(stack_depth), .status(status),
    .skip_count(skip_count), .top_remaining(top_remaining),
    .byte_offset(byte_offset)
  );

  // Predicted stack and varint parser state.
  bit        lvl_inf[NEST];
  bit [55:0] lvl_left[NEST];
  int        open_levels;
  bit        want_size;
  int        vint_left;
  int        vint_len;
  bit [55:0] vint_val;
  bit [31:0] held_id;
  bit [63:0] stream_pos;

  hdr_result_t  expected_results[$];
  stream_item_t pending_stream[$];
  stim_row_t    dir_rows[$];

  int  errors = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  cycles = 0;
  int  status_seen[8];
  int  pushes_seen = 0;
  bit  calm = 0;
  bit  held_off = 0;
  int  hold_left = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A finite top limits reads; an infinite or missing top does not.
  function automatic bit top_admits(bit [55:0] n);
    if (open_levels == 0 || open_levels > NEST) return 1'b1;
    if (lvl_inf[open_levels-1]) return 1'b1;
    return lvl_left[open_levels-1] >= n;
  endfunction

  // Subtract from every finite level, outermost first, cutting at zero.
  function automatic void consume_bytes(bit [55:0] n);
    for (int i = 0; i < open_levels && i < NEST; i++) begin
      if (!lvl_inf[i]) begin
        lvl_left[i] = lvl_left[i] - n;
        if (lvl_left[i] == 0) begin
          open_levels = i;
          break;
        end
      end
    end
    stream_pos = stream_pos + 64'(n);
  endfunction

  function automatic void restart_varint();
    want_size = 1'b0;
    vint_left = 0;
    vint_len = 0;
    vint_val = '0;
  endfunction

  function automatic bit [2:0] open_element(bit [55:0] sz, bit inf);
    int p;
    if (open_levels >= NEST) return ebmlt_pkg::ST_TOO_DEEP;
    if (open_levels < 1) return ebmlt_pkg::ST_NO_PARENT;
    p = open_levels - 1;
    if (!lvl_inf[p]) begin
      if (inf) return ebmlt_pkg::ST_INF_IN_FIN;
      if (lvl_left[p] < sz) return ebmlt_pkg::ST_EXCEEDS;
    end
    lvl_inf[open_levels] = inf;
    lvl_left[open_levels] = sz;
    open_levels++;
    return ebmlt_pkg::ST_OK;
  endfunction

  function automatic bit [2:0] parse_header_byte(bit [7:0] b, ref hdr_result_t r);
    bit [55:0] all_ones;
    bit        inf;
    bit [2:0]  st;
    int        w;
    if (!top_admits(56'd1)) begin
      restart_varint();
      return ebmlt_pkg::ST_READ_PAST;
    end
    consume_bytes(56'd1);
    if (vint_left == 0) begin
      if (b == 8'h00) begin
        restart_varint();
        return ebmlt_pkg::ST_BAD_VINT;
      end
      w = 1;
      while ((b & (8'h80 >> (w - 1))) == 0) w++;
      vint_len = w;
      vint_val = 56'(b & (8'hFF >> w));
      vint_left = w - 1;
    end else begin
      vint_val = (vint_val << 8) | 56'(b);
      vint_left--;
    end
    if (vint_left != 0) return ebmlt_pkg::ST_OK;
    if (!want_size) begin
      held_id = vint_val[31:0];
      want_size = 1'b1;
      vint_val = '0;
      vint_len = 0;
      return ebmlt_pkg::ST_OK;
    end
    all_ones = 56'((64'd1 << (7 * vint_len)) - 64'd1);
    inf = (vint_val == all_ones);
    r.sz = vint_val;
    restart_varint();
    st = open_element(r.sz, inf);
    if (st == ebmlt_pkg::ST_OK) begin
      r.hd = 1'b1;
      r.id = held_id;
      r.inf = inf;
    end else begin
      r.sz = '0;
    end
    return st;
  endfunction

  // One accepted item in, one expected result out.
  function automatic hdr_result_t track_item(bit [1:0] f, bit [7:0] d, bit [55:0] c);
    hdr_result_t r;
    bit [55:0]   skip;
    r = '{default: '0};
    case (f)
      ebmlt_pkg::FUNC_HEADER: begin
        r.st = parse_header_byte(d, r);
      end
      ebmlt_pkg::FUNC_CONSUME: begin
        if (!top_admits(c)) begin
          restart_varint();
          r.st = ebmlt_pkg::ST_READ_PAST;
        end else begin
          consume_bytes(c);
        end
      end
      ebmlt_pkg::FUNC_CLOSE: begin
        if (open_levels >= 1 && open_levels <= NEST && !lvl_inf[open_levels-1]) begin
          skip = lvl_left[open_levels-1];
          consume_bytes(skip);
          r.skip = skip;
        end
      end
      default: ;
    endcase
    r.dep = 4'(open_levels);
    if (open_levels >= 1 && open_levels <= NEST && !lvl_inf[open_levels-1])
      r.top = lvl_left[open_levels-1];
    r.off = stream_pos;
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // Drive one item from a falling edge and wait for its acceptance.
  task automatic send(bit [1:0] f, bit [7:0] d, bit [55:0] c);
    hdr_result_t r;
    while (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    data_byte <= d;
    count <= c;
    do @(posedge clk); while (!in_ready);
    r = track_item(f, d, c);
    expected_results.push_back(r);
    status_seen[r.st]++;
    if (r.hd) pushes_seen++;
    n_sent++;
    @(negedge clk);
  endtask

  // Append a varint of the given width to the pending stream.
  task automatic queue_vint(bit [63:0] v, int w);
    bit [7:0] first;
    first = (w == 8) ? 8'h01 : ((8'h80 >> (w - 1)) | 8'(v >> (8 * (w - 1))));
    pending_stream.push_back('{ebmlt_pkg::FUNC_HEADER, first, 56'd0});
    for (int k = w - 2; k >= 0; k--)
      pending_stream.push_back('{ebmlt_pkg::FUNC_HEADER, 8'(v >> (8 * k)), 56'd0});
  endtask

  // Choose the next random stretch of stream, shaped by the current top.
  task automatic plan_random();
    int        r, idw, szw;
    bit        fin_top;
    bit [55:0] room, sz, lim;
    bit [63:0] idv;
    fin_top = open_levels >= 1 && !lvl_inf[open_levels-1];
    room = fin_top ? lvl_left[open_levels-1] : 56'd0;
    r = $urandom_range(99);
    if (r < 45) begin
      idw = ($urandom_range(19) == 0) ? 8 : $urandom_range(1, 4);
      idv = {$urandom, $urandom} & ((64'd1 << (7 * idw)) - 64'd1);
      if (open_levels <= 6 && $urandom_range(99) < 10) begin
        szw = $urandom_range(1, 8);
        sz = 56'((64'd1 << (7 * szw)) - 64'd1);
      end else begin
        if ($urandom_range(29) == 0) begin
          sz = 56'({$urandom, $urandom});
          sz = sz >> $urandom_range(55);
        end else if (fin_top && $urandom_range(99) < 75) begin
          lim = (room > 56'd12) ? room - 56'd12 : 56'd0;
          if (lim > 56'd60) lim = 56'd60;
          sz = 56'($urandom_range(0, 32'(lim)));
        end else begin
          sz = 56'($urandom_range(0, 60));
        end
        szw = 1;
        while (szw < 8 && 64'(sz) >= (64'd1 << (7 * szw)) - 64'd1) szw++;
        if ($urandom_range(5) == 0) szw = $urandom_range(szw, 8);
      end
      queue_vint(idv, idw);
      queue_vint(64'(sz), szw);
    end else if (r < 70) begin
      if (fin_top) sz = 56'($urandom_range(0, 32'((room > 40) ? 56'd40 : room)));
      else if ($urandom_range(9) == 0) sz = 56'({$urandom, $urandom});
      else sz = 56'($urandom_range(0, 40));
      pending_stream.push_back('{ebmlt_pkg::FUNC_CONSUME, 8'd0, sz});
    end else if (r < 82) begin
      pending_stream.push_back('{ebmlt_pkg::FUNC_CLOSE, 8'd0, 56'd0});
    end else begin
      pending_stream.push_back('{2'($urandom_range(3)), 8'($urandom),
                                 56'({$urandom, $urandom})});
    end
  endtask

  // Result checker: every taken result against the oldest expectation.
  always @(posedge clk) begin
    hdr_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", 64'(status), 64'd0);
      end else begin
        e = expected_results.pop_front();
        n_checked++;
        if (header_done !== e.hd) report("header_done", 64'(header_done), 64'(e.hd));
        if (elem_id !== e.id) report("elem_id", 64'(elem_id), 64'(e.id));
        if (elem_size !== e.sz) report("elem_size", 64'(elem_size), 64'(e.sz));
        if (is_infinite !== e.inf) report("is_infinite", 64'(is_infinite), 64'(e.inf));
        if (stack_depth !== e.dep) report("stack_depth", 64'(stack_depth), 64'(e.dep));
        if (status !== e.st) report("status", 64'(status), 64'(e.st));
        if (skip_count !== e.skip) report("skip_count", 64'(skip_count), 64'(e.skip));
        if (top_remaining !== e.top) report("top_remaining", 64'(top_remaining), 64'(e.top));
        if (byte_offset !== e.off) report("byte_offset", byte_offset, e.off);
      end
    end
  end

  // Receiver: random stalls, a long hold-off once, none while calm.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!held_off && n_checked >= 400) begin
      held_off <= 1'b1;
      hold_left <= 120;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Directed table, then random stream, then drain.
  initial begin
    stim_row_t    row;
    stream_item_t it;
    hdr_result_t  got;
    int           drain;
    rst = 1'b1;
    in_valid = 1'b0;
    func = ebmlt_pkg::FUNC_HEADER;
    data_byte = '0;
    count = '0;
    for (int i = 0; i < NEST; i++) begin
      lvl_inf[i] = 1'b0;
      lvl_left[i] = '0;
    end
    lvl_inf[0] = 1'b1;
    open_levels = 1;
    held_id = '0;
    stream_pos = '0;
    restart_varint();

    // Close on the root, a bad first byte, pushes, refusals, an 8-byte ID
    // and an element of size zero.
    dir_rows = '{
      '{ebmlt_pkg::FUNC_CLOSE,   8'h00, 56'd0, 1'b1, ebmlt_pkg::ST_OK,         4'd1},
      '{ebmlt_pkg::FUNC_HEADER,  8'h00, 56'd0, 1'b1, ebmlt_pkg::ST_BAD_VINT,   4'd1},
      '{ebmlt_pkg::FUNC_HEADER,  8'h81, 56'd0, 1'b0, ebmlt_pkg::ST_OK,         4'd0},
      '{ebmlt_pkg::FUNC_HEADER,  8'hFF, 56'd0, 1'b1, ebmlt_pkg::ST_OK,         4'd2},
      '{ebmlt_pkg::FUNC_HEADER,  8'h81, 56'd0, 1'b0, ebmlt_pkg::ST_OK,         4'd0},
      '{ebmlt_pkg::FUNC_HEADER,  8'h85, 56'd0, 1'b1, ebmlt_pkg::ST_OK,         4'd3},
      '{ebmlt_pkg::FUNC_CONSUME, 8'h00, 56'd6, 1'b1, ebmlt_pkg::ST_READ_PAST,  4'd3},
      '{ebmlt_pkg::FUNC_CONSUME, 8'h00, 56'd2, 1'b0, ebmlt_pkg::ST_OK,         4'd0},
      '{ebmlt_pkg::FUNC_CLOSE,   8'h00, 56'd0, 1'b1, ebmlt_pkg::ST_OK,         4'd2},
      '{ebmlt_pkg::FUNC_HEADER,  8'h81, 56'd0, 1'b0, ebmlt_pkg::ST_OK,         4'd0},
      '{ebmlt_pkg::FUNC_HEADER,  8'h8A, 56'd0, 1'b1, ebmlt_pkg::ST_OK,         4'd3},
      '{ebmlt_pkg::FUNC_HEADER,  8'h81, 56'd0, 1'b0, ebmlt_pkg::ST_OK,         4'd0},
      '{ebmlt_pkg::FUNC_HEADER,  8'hFF, 56'd0, 1'b1, ebmlt_pkg::ST_INF_IN_FIN, 4'd3},
      '{ebmlt_pkg::FUNC_HEADER,  8'h81, 56'd0, 1'b0, ebmlt_pkg::ST_OK,         4'd0},
      '{ebmlt_pkg::FUNC_HEADER,  8'h88, 56'd0, 1'b1, ebmlt_pkg::ST_EXCEEDS,    4'd3},
      '{ebmlt_pkg::FUNC_CONSUME, 8'h00, 56'd0, 1'b0, ebmlt_pkg::ST_OK,         4'd0},
      '{FUNC_UNUSED,             8'hA5, 56'd9, 1'b1, ebmlt_pkg::ST_OK,         4'd3},
      '{ebmlt_pkg::FUNC_CONSUME, 8'h00, 56'd6, 1'b1, ebmlt_pkg::ST_OK,         4'd2},
      '{ebmlt_pkg::FUNC_CONSUME, 8'h00, MASK56, 1'b1, ebmlt_pkg::ST_OK,        4'd2},
      '{ebmlt_pkg::FUNC_HEADER,  8'h01, 56'd0, 1'b0, ebmlt_pkg::ST_OK,         4'd0},
      '{ebmlt_pkg::FUNC_HEADER,  8'h12, 56'd0, 1'b0, ebmlt_pkg::ST_OK,         4'd0},
      '{ebmlt_pkg::FUNC_HEADER,  8'h34, 56'd0, 1'b0, ebmlt_pkg::ST_OK,         4'd0},
      '{ebmlt_pkg::FUNC_HEADER,  8'h56, 56'd0, 1'b0, ebmlt_pkg::ST_OK,         4'd0},
      '{ebmlt_pkg::FUNC_HEADER,  8'h78, 56'd0, 1'b0, ebmlt_pkg::ST_OK,         4'd0},
      '{ebmlt_pkg::FUNC_HEADER,  8'h9A, 56'd0, 1'b0, ebmlt_pkg::ST_OK,         4'd0},
      '{ebmlt_pkg::FUNC_HEADER,  8'hBC, 56'd0, 1'b0, ebmlt_pkg::ST_OK,         4'd0},
      '{ebmlt_pkg::FUNC_HEADER,  8'hDE, 56'd0, 1'b0, ebmlt_pkg::ST_OK,         4'd0},
      '{ebmlt_pkg::FUNC_HEADER,  8'h80, 56'd0, 1'b1, ebmlt_pkg::ST_OK,         4'd3},
      '{ebmlt_pkg::FUNC_HEADER,  8'h81, 56'd0, 1'b1, ebmlt_pkg::ST_READ_PAST,  4'd3}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send(row.f, row.d, row.c);
      got = expected_results[$];
      if (row.known && (got.st != row.st || got.dep != row.dep))
        report($sformatf("directed row %0d", i), 64'({got.st, got.dep}),
               64'({row.st, row.dep}));
    end

    // Random part, with one stretch free of idling on both sides.
    while (n_sent < dir_rows.size() + RANDOM_ITEMS) begin
      calm = (n_sent >= 900 && n_sent < 1100);
      if (pending_stream.size() == 0) plan_random();
      it = pending_stream.pop_front();
      send(it.f, it.d, it.c);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain, then keep watching for anything stray.
    while (expected_results.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 20) begin
      @(posedge clk);
      drain++;
    end

    $display("%0d items driven, %0d results checked, %0d elements opened",
             n_sent, n_checked, pushes_seen);
    $display("status mix: ok %0d, bad varint %0d, too deep %0d, inf in finite %0d",
             status_seen[ebmlt_pkg::ST_OK], status_seen[ebmlt_pkg::ST_BAD_VINT],
             status_seen[ebmlt_pkg::ST_TOO_DEEP], status_seen[ebmlt_pkg::ST_INF_IN_FIN]);
    $display("            exceeds %0d, read past %0d",
             status_seen[ebmlt_pkg::ST_EXCEEDS], status_seen[ebmlt_pkg::ST_READ_PAST]);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
